// ===== rtl/bloom_filter_murmur3_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Bloom filter unit checkers
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_MURMUR3_UNIT_ASSERT_SVH
`define BLOOM_FILTER_MURMUR3_UNIT_ASSERT_SVH

// same-cycle implication
`define BFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfm assertion failed");

// next-cycle implication
`define BFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfm assertion failed");

`endif

// ===== rtl/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package bfm_pkg;

  localparam int FILTER_BITS   = 4096;
  localparam int MAX_KEY_BYTES = 64;
  localparam int MAX_HASHES    = 16;

  localparam int IDX_W  = $clog2(FILTER_BITS);
  localparam int KEY_AW = $clog2(MAX_KEY_BYTES);
  localparam int LEN_W  = 7;
  localparam int BC_W   = 13;
  localparam int HC_W   = 5;
  localparam int HCNT_W = $clog2(MAX_HASHES);
  localparam int DIVC_W = 5;

  localparam logic [31:0] MM_C1     = 32'hCC9E2D51;
  localparam logic [31:0] MM_C2     = 32'h1B873593;
  localparam logic [31:0] MM_N      = 32'hE6546B64;
  localparam logic [31:0] MM_F1     = 32'h85EBCA6B;
  localparam logic [31:0] MM_F2     = 32'hC2B2AE35;
  localparam logic [31:0] SEED_STEP = 32'h9E3779B9;

  localparam logic CFG_BIT_COUNT  = 1'b0;
  localparam logic CFG_HASH_COUNT = 1'b1;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  // spare code, handled as a query
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    ST_RST_CLR, ST_CLR, ST_IDLE, ST_HSTART, ST_RD, ST_CAP, ST_MUL1, ST_MUL2,
    ST_MIX, ST_FIN0, ST_FIN1, ST_FIN2, ST_DIV, ST_BIT, ST_CHK, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLR_KEY, OP_CLR_STEP, OP_LOAD, OP_HINIT, OP_RD, OP_CAP, OP_MUL1,
    OP_MUL2, OP_MIX, OP_FIN0, OP_FIN1, OP_FIN2, OP_DIV, OP_BIT, OP_CHK
  } op_t;

  typedef struct packed {
    op_t  op;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic cap_full;
    logic cap_end;
    logic key_done;
    logic clr_done;
    logic div_done;
    logic last_hash;
    logic is_insert;
    logic ovf_now;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/bfm_ram.sv =====
// ----------------------------------------------------------------------------
// bfm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/bfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfm_ctrl
// Sequencer: input handshake, clear sweep, hash walk and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module bfm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_mode,
  input  wire logic          in_last_byte,
  output logic               in_stall,
  input  wire bfm_pkg::stat_t st,
  output bfm_pkg::cmd_t      cmd
);
  import bfm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RST_CLR: if (st.clr_done) state_nxt = ST_IDLE;
      ST_CLR:     if (st.clr_done) state_nxt = ST_EMIT;
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_CLEAR) begin
            state_nxt = ST_CLR;
          end else if (in_last_byte) begin
            state_nxt = st.ovf_now ? ST_EMIT : ST_HSTART;
          end
        end
      end
      ST_HSTART: state_nxt = st.len_zero ? ST_FIN0 : ST_RD;
      ST_RD:     state_nxt = ST_CAP;
      ST_CAP:    state_nxt = (st.cap_full || st.cap_end) ? ST_MUL1 : ST_RD;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_MIX;
      ST_MIX:    state_nxt = st.key_done ? ST_FIN0 : ST_RD;
      ST_FIN0:   state_nxt = ST_FIN1;
      ST_FIN1:   state_nxt = ST_FIN2;
      ST_FIN2:   state_nxt = ST_DIV;
      ST_DIV:    if (st.div_done) state_nxt = ST_BIT;
      ST_BIT: begin
        if (!st.is_insert) begin
          state_nxt = ST_CHK;
        end else begin
          state_nxt = st.last_hash ? ST_EMIT : ST_HSTART;
        end
      end
      ST_CHK:  state_nxt = st.last_hash ? ST_EMIT : ST_HSTART;
      ST_EMIT: if (!st.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NOP;
    cmd.emit = 1'b0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_RST_CLR, ST_CLR: cmd.op = OP_CLR_STEP;
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = (in_mode == MODE_CLEAR) ? OP_CLR_KEY : OP_LOAD;
        end
      end
      ST_HSTART: cmd.op = OP_HINIT;
      ST_RD:     cmd.op = OP_RD;
      ST_CAP:    cmd.op = OP_CAP;
      ST_MUL1:   cmd.op = OP_MUL1;
      ST_MUL2:   cmd.op = OP_MUL2;
      ST_MIX:    cmd.op = OP_MIX;
      ST_FIN0:   cmd.op = OP_FIN0;
      ST_FIN1:   cmd.op = OP_FIN1;
      ST_FIN2:   cmd.op = OP_FIN2;
      ST_DIV:    cmd.op = OP_DIV;
      ST_BIT:    cmd.op = OP_BIT;
      ST_CHK:    cmd.op = OP_CHK;
      ST_EMIT:   cmd.emit = !st.out_busy;
      default:   cmd.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bfm_dpath.sv =====
// ----------------------------------------------------------------------------
// bfm_dpath
// Key buffer, MurmurHash3 round unit, bit-serial modulo, filter store and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none
module bfm_dpath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [bfm_pkg::BC_W-1:0] cfg_data,
  input  wire logic [1:0]              in_mode,
  input  wire logic [7:0]              in_key_byte,
  input  wire logic                    in_byte_valid,
  input  wire logic                    in_last_byte,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_found,
  output logic                         out_status,
  input  wire bfm_pkg::cmd_t           cmd,
  output bfm_pkg::stat_t               st
);
  import bfm_pkg::*;

  logic [BC_W-1:0]   bit_count_r;
  logic [HC_W-1:0]   hash_count_r;
  logic [BC_W-1:0]   bc_eff;
  logic [HC_W-1:0]   hc_eff;

  logic [LEN_W-1:0]  len_r, p_r;
  logic              ovf_r, err_r, ins_r, found_r, full_r;
  logic [31:0]       h_r, k_r, t_r, seed_r;
  logic [HCNT_W-1:0] hcnt_r;
  logic [IDX_W-1:0]  rem_r, clr_cnt_r;
  logic [DIVC_W-1:0] div_cnt_r;
  logic              out_valid_r, out_found_r, out_status_r;

  logic [7:0]        key_rd;
  logic              fb_rd;
  logic              key_we, fb_we, fb_wdata;
  logic [IDX_W-1:0]  fb_waddr;

  logic [31:0]       mix_x, mix_rot, fin0_x, fin0_y, fin1_x;
  logic [BC_W-1:0]   trial;

  assign bc_eff = (bit_count_r == '0) ? BC_W'(1) :
                  (bit_count_r > BC_W'(FILTER_BITS)) ? BC_W'(FILTER_BITS) : bit_count_r;
  assign hc_eff = (hash_count_r == '0) ? HC_W'(1) :
                  (hash_count_r > HC_W'(MAX_HASHES)) ? HC_W'(MAX_HASHES) : hash_count_r;

  assign mix_x   = h_r ^ t_r;
  assign mix_rot = {mix_x[18:0], mix_x[31:19]};
  assign fin0_x  = h_r ^ {{(32-LEN_W){1'b0}}, len_r};
  assign fin0_y  = fin0_x ^ (fin0_x >> 16);
  assign fin1_x  = h_r ^ (h_r >> 13);
  assign trial   = {rem_r, h_r[31]};

  assign key_we   = (cmd.op == OP_LOAD) && in_byte_valid &&
                    (len_r < LEN_W'(MAX_KEY_BYTES));
  assign fb_we    = (cmd.op == OP_CLR_STEP) || ((cmd.op == OP_BIT) && ins_r);
  assign fb_wdata = (cmd.op != OP_CLR_STEP);
  assign fb_waddr = (cmd.op == OP_CLR_STEP) ? clr_cnt_r : rem_r;

  bfm_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (len_r[KEY_AW-1:0]),
    .wdata (in_key_byte),
    .raddr (p_r[KEY_AW-1:0]),
    .rdata (key_rd)
  );

  bfm_ram #(.WIDTH(1), .DEPTH(FILTER_BITS)) u_filter_ram (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (rem_r),
    .rdata (fb_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= BC_W'(FILTER_BITS);
      hash_count_r <= HC_W'(1);
      len_r        <= '0;
      ovf_r        <= 1'b0;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BIT_COUNT) begin
          bit_count_r <= cfg_data;
        end else begin
          hash_count_r <= cfg_data[HC_W-1:0];
        end
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        len_r       <= '0;
        ovf_r       <= 1'b0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (cmd.op)
        OP_CLR_KEY: begin
          len_r     <= '0;
          ovf_r     <= 1'b0;
          clr_cnt_r <= '0;
        end
        OP_CLR_STEP: clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        OP_LOAD: begin
          if (in_byte_valid) begin
            if (len_r < LEN_W'(MAX_KEY_BYTES)) begin
              len_r <= len_r + LEN_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found_r  <= found_r & ~ins_r & ~err_r;
      out_status_r <= err_r;
    end
    unique case (cmd.op)
      OP_CLR_KEY: begin
        err_r   <= 1'b0;
        found_r <= 1'b0;
        ins_r   <= 1'b1;
      end
      OP_LOAD: begin
        if (in_last_byte) begin
          err_r   <= st.ovf_now;
          ins_r   <= (in_mode == MODE_INSERT);
          found_r <= 1'b1;
          seed_r  <= '0;
          hcnt_r  <= '0;
        end
      end
      OP_HINIT: begin
        h_r <= seed_r;
        p_r <= '0;
        k_r <= '0;
      end
      OP_CAP: begin
        k_r    <= k_r | ({24'b0, key_rd} << {p_r[1:0], 3'b000});
        full_r <= (p_r[1:0] == 2'd3);
        p_r    <= p_r + LEN_W'(1);
      end
      OP_MUL1: t_r <= k_r * MM_C1;
      OP_MUL2: t_r <= {t_r[16:0], t_r[31:17]} * MM_C2;
      OP_MIX: begin
        h_r <= full_r ? ((mix_rot << 2) + mix_rot + MM_N) : mix_x;
        k_r <= '0;
      end
      OP_FIN0: h_r <= fin0_y * MM_F1;
      OP_FIN1: h_r <= fin1_x * MM_F2;
      OP_FIN2: begin
        h_r       <= h_r ^ (h_r >> 16);
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      OP_DIV: begin
        // restoring remainder, one dividend bit per cycle
        rem_r     <= (trial >= bc_eff) ? IDX_W'(trial - bc_eff) : trial[IDX_W-1:0];
        h_r       <= h_r << 1;
        div_cnt_r <= div_cnt_r + DIVC_W'(1);
      end
      OP_BIT: begin
        if (ins_r) begin
          hcnt_r <= hcnt_r + HCNT_W'(1);
          seed_r <= seed_r + SEED_STEP;
        end
      end
      OP_CHK: begin
        if (!fb_rd) begin
          found_r <= 1'b0;
        end
        hcnt_r <= hcnt_r + HCNT_W'(1);
        seed_r <= seed_r + SEED_STEP;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.len_zero  = (len_r == '0);
    st.cap_full  = (p_r[1:0] == 2'd3);
    st.cap_end   = ((p_r + LEN_W'(1)) == len_r);
    st.key_done  = (p_r == len_r);
    st.clr_done  = &clr_cnt_r;
    st.div_done  = &div_cnt_r;
    st.last_hash = ({1'b0, hcnt_r} == (hc_eff - HC_W'(1)));
    st.is_insert = ins_r;
    st.ovf_now   = ovf_r | (in_byte_valid & (len_r == LEN_W'(MAX_KEY_BYTES)));
    st.out_busy  = out_valid_r & out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

// ===== rtl/bloom_filter_murmur3_unit.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_murmur3_unit
// Bloom filter engine with seeded MurmurHash3_x86_32 bit indexing.
// ----------------------------------------------------------------------------
// Key bytes are taken one per cycle while the unit is idle. On the last byte
// of a key that did not overflow, the unit runs hash_count hashes (clamped to
// 1..16) one after another; each hash reads and captures every key byte from
// the key RAM, runs two multiplies and the mix per 4-byte block or tail, then
// finalization, a bit-serial modulo and the filter access. A clear item sweeps
// the 4096-entry filter RAM one bit per cycle, and the same clearing pass runs
// after reset before any item is taken; configuration writes are taken at all
// times. The result register decouples the output, so bytes of the next key
// keep flowing while a result waits to be transferred.
`default_nettype none
module bloom_filter_murmur3_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [bfm_pkg::BC_W-1:0] cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_mode,
  input  wire logic [7:0]              in_key_byte,
  input  wire logic                    in_byte_valid,
  input  wire logic                    in_last_byte,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_found,
  output logic                         out_status
);
  import bfm_pkg::*;

  cmd_t  cmd;
  stat_t st;

  bfm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_mode      (in_mode),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .st           (st),
    .cmd          (cmd)
  );

  bfm_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mode       (in_mode),
    .in_key_byte   (in_key_byte),
    .in_byte_valid (in_byte_valid),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_status    (out_status),
    .cmd           (cmd),
    .st            (st)
  );

endmodule
`default_nettype wire

// ===== rtl/bfm_checker.sv =====
// ----------------------------------------------------------------------------
// bfm_checker
// Port-level checks on the Bloom filter unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bloom_filter_murmur3_unit_assert.svh"
module bfm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_mode,
  input wire logic       in_last_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_found,
  input wire logic       out_status
);
  import bfm_pkg::*;

  // an overflowed key never reports a hit
  `BFM_ASSERT_NOW(a_err_not_found, out_valid && out_status, !out_found)
  // stalled result holds
  `BFM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // a clear transfer starts the filter sweep
  `BFM_ASSERT_NEXT(a_clr_busy, in_valid && !in_stall && in_mode == MODE_CLEAR, in_stall)
  // end of key blocks input until its result is handed off
  `BFM_ASSERT_NEXT(a_key_end_busy, in_valid && !in_stall && in_last_byte, in_stall)

endmodule

bind bloom_filter_murmur3_unit bfm_checker u_bfm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_mode      (in_mode),
  .in_last_byte (in_last_byte),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_found    (out_found),
  .out_status   (out_status)
);
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Bloom filter unit testbench
// Streams key bytes, clears and register settings into the unit and checks
// every found/status result against a behavioral MurmurHash3 Bloom predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
  import bfm_pkg::*;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] kbyte;
    logic       bv;
    logic       last;
  } item_t;

  typedef struct packed {
    logic found;
    logic status;
  } result_t;

  typedef struct packed {
    int           n;
    logic [159:0] b;
  } saved_key_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_BIT_COUNT;
  logic [BC_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = MODE_INSERT;
  logic [7:0] in_key_byte = 8'h00;
  logic in_byte_valid = 1'b0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found;
  logic out_status;

  bloom_filter_murmur3_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_key_byte(in_key_byte), .in_byte_valid(in_byte_valid),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found(out_found), .out_status(out_status)
  );

  // predictor state
  logic       filt [FILTER_BITS];
  logic [7:0] key_buf [MAX_KEY_BYTES];
  int         key_len = 0;
  logic       key_ovf = 1'b0;
  int         bits_used = FILTER_BITS;
  int         hashes_used = 1;

  item_t      pending_items[$];
  result_t    expected_results[$];
  saved_key_t inserted_keys[$];

  int  errors = 0;
  int  checked = 0;
  int  clears_sent = 0;
  int  keys_sent = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  hold_left = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  bit  quiet = 0;
  longint cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
    rotl = (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_block(input logic [31:0] k);
    logic [31:0] t;
    t = k * MM_C1;
    t = rotl(t, 15);
    mix_block = t * MM_C2;
  endfunction

  function automatic logic [31:0] murmur_digest(input int n, input logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] blk;
    int base;
    int rem;
    h = seed;
    for (int i = 0; i < n / 4; i++) begin
      blk = {key_buf[4*i+3], key_buf[4*i+2], key_buf[4*i+1], key_buf[4*i]};
      h = h ^ mix_block(blk);
      h = rotl(h, 13);
      h = h * 32'd5 + MM_N;
    end
    base = (n / 4) * 4;
    rem = n % 4;
    k = '0;
    if (rem >= 3) k = k ^ (32'(key_buf[base+2]) << 16);
    if (rem >= 2) k = k ^ (32'(key_buf[base+1]) << 8);
    if (rem >= 1) begin
      k = k ^ 32'(key_buf[base]);
      h = h ^ mix_block(k);
    end
    h = h ^ 32'(n);
    h = h ^ (h >> 16);
    h = h * MM_F1;
    h = h ^ (h >> 13);
    h = h * MM_F2;
    h = h ^ (h >> 16);
    murmur_digest = h;
  endfunction

  // advance the filter model by one accepted transfer
  task automatic predict_item(input item_t it);
    result_t r;
    logic [31:0] idx;
    logic hit;
    if (it.mode == MODE_CLEAR) begin
      foreach (filt[i]) filt[i] = 1'b0;
      key_len = 0;
      key_ovf = 1'b0;
      expected_results.push_back('{found: 1'b0, status: 1'b0});
      return;
    end
    if (it.bv) begin
      if (key_len < MAX_KEY_BYTES) begin
        key_buf[key_len] = it.kbyte;
        key_len++;
      end else key_ovf = 1'b1;
    end
    if (!it.last) return;
    if (key_ovf) begin
      r = '{found: 1'b0, status: 1'b1};
    end else begin
      hit = 1'b1;
      for (int i = 0; i < hashes_used; i++) begin
        idx = murmur_digest(key_len, 32'(i) * SEED_STEP) % 32'(bits_used);
        if (it.mode == MODE_INSERT) filt[idx] = 1'b1;
        else if (!filt[idx]) hit = 1'b0;
      end
      r = '{found: (it.mode == MODE_INSERT) ? 1'b0 : hit, status: 1'b0};
    end
    key_len = 0;
    key_ovf = 1'b0;
    expected_results.push_back(r);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      foreach (filt[i]) filt[i] = 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_item('{mode: in_mode, kbyte: in_key_byte, bv: in_byte_valid,
                       last: in_last_byte});
      if (in_valid && in_stall) begin
        // hold payload
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        in_gap <= $urandom_range(1, 14) - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item_t nx;
        nx = pending_items.pop_front();
        in_valid <= 1'b1;
        in_mode <= nx.mode;
        in_key_byte <= nx.kbyte;
        in_byte_valid <= nx.bv;
        in_last_byte <= nx.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        result_t e;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result found=%0b status=%0b", $time,
                   out_found, out_status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          checked++;
          if (out_found !== e.found) begin
            $display("%0t: found expected %0b actual %0b", $time, e.found, out_found);
            errors++;
          end
          if (out_status !== e.status) begin
            $display("%0t: status expected %0b actual %0b", $time, e.status, out_status);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done && hold_left == 0) begin
        hold_left <= 3000;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= (out_gap > 1);
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap <= $urandom_range(1, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               expected_results.size());
      $display("bloom_filter_murmur3_unit: mismatch");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] m, input logic [7:0] b,
                           input logic v, input logic l);
    pending_items.push_back('{mode: m, kbyte: b, bv: v, last: l});
  endtask

  // a key of n bytes; partial bytes carry random modes
  task automatic push_key(input int n, input logic [1:0] m, input logic [159:0] pat,
                          input bit use_pat);
    logic [7:0] b;
    saved_key_t sk;
    sk.n = n;
    sk.b = '0;
    for (int i = 0; i < n; i++) begin
      b = use_pat ? pat[8*i +: 8] : 8'($urandom);
      if (i < 20) sk.b[8*i +: 8] = b;
      if (i == n - 1 && $urandom_range(0, 3) != 0) begin
        push_item(m, b, 1'b1, 1'b1);
      end else begin
        logic [1:0] pm;
        pm = 2'($urandom_range(0, 3));
        if (pm == MODE_CLEAR) pm = MODE_QUERY;
        push_item(pm, b, 1'b1, 1'b0);
      end
    end
    if (n == 0 || !pending_items[$].last)
      push_item(m, 8'($urandom), 1'b0, 1'b1);
    if (m == MODE_INSERT && n <= 20 && !use_pat) inserted_keys.push_back(sk);
    keys_sent++;
  endtask

  task automatic wait_idle();
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= BC_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BIT_COUNT) begin
      bits_used = val & 13'h1FFF;
      if (bits_used < 1) bits_used = 1;
      if (bits_used > FILTER_BITS) bits_used = FILTER_BITS;
    end else begin
      hashes_used = val & 5'h1F;
      if (hashes_used < 1) hashes_used = 1;
      if (hashes_used > MAX_HASHES) hashes_used = MAX_HASHES;
    end
  endtask

  task automatic random_burst(input int count);
    int budget;
    int n;
    int pick;
    logic [1:0] m;
    saved_key_t sk;
    budget = count;
    while (budget > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        push_item(MODE_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
        clears_sent++;
        inserted_keys.delete();
        budget--;
      end else if (pick < 7) begin
        // noise: empty non-final byte
        push_item(2'($urandom_range(0, 1)), 8'($urandom), 1'b0, 1'b0);
      end else if (pick < 30 && inserted_keys.size() > 0) begin
        sk = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        m = $urandom_range(0, 1) ? MODE_QUERY : MODE_UNUSED;
        push_key(sk.n, m, sk.b, 1'b1);
        budget -= sk.n + 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) n = $urandom_range(0, 8);
        else if (pick < 96) n = $urandom_range(9, 20);
        else n = $urandom_range(60, 70);
        m = $urandom_range(0, 2) == 0 ? MODE_INSERT : 2'($urandom_range(0, 1));
        if (m == MODE_QUERY && $urandom_range(0, 3) == 0) m = MODE_UNUSED;
        push_key(n, m, '0, 1'b0);
        budget -= n + 1;
      end
      if (inserted_keys.size() > 32) void'(inserted_keys.pop_front());
    end
  endtask

  initial begin
    int bc_set [8];
    int hc_set [8];
    bc_set = '{1, 4096, 13, 0, 8191, 100, 257, 4096};
    hc_set = '{1, 16, 3, 0, 31, 5, 2, 1};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default registers, edge keys and modes
    push_key(0, MODE_INSERT, '0, 1'b1);
    push_key(0, MODE_QUERY, '0, 1'b1);
    push_key(1, MODE_QUERY, 160'hFF, 1'b1);
    push_key(3, MODE_INSERT, 160'hFF00FF, 1'b1);
    push_key(3, MODE_QUERY, 160'hFF00FF, 1'b1);
    push_key(4, MODE_UNUSED, 160'hFFFFFFFF, 1'b1);
    push_item(MODE_INSERT, 8'h5A, 1'b1, 1'b0);
    push_item(MODE_CLEAR, 8'hA5, 1'b1, 1'b0);
    push_key(2, MODE_INSERT, 160'h0100, 1'b1);
    push_item(MODE_CLEAR, 8'h00, 1'b0, 1'b1);
    push_key(2, MODE_QUERY, 160'h0100, 1'b1);
    clears_sent += 2;
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_BIT_COUNT, bc_set[p]);
      write_reg(CFG_HASH_COUNT, hc_set[p]);
      if (p == 7) quiet = 1;
      if (p == 2) begin
        // stall the output for a long stretch while short keys keep coming
        hold_req = 1;
        for (int i = 0; i < 30; i++) push_key($urandom_range(0, 2), MODE_INSERT, '0, 1'b0);
      end
      if (p == 0) begin
        push_key(64, MODE_INSERT, {20{8'hFF}}, 1'b0);
        push_key(65, MODE_QUERY, '0, 1'b0);
      end
      random_burst(200);
      wait_idle();
    end

    wait_idle();
    repeat (200) @(posedge clk);
    $display("covered %0d keys and %0d clears over 8 register settings", keys_sent,
             clears_sent);
    $display("%0d results checked, %0d errors", checked, errors);
    if (errors == 0 && expected_results.size() == 0)
      $display("bloom_filter_murmur3_unit: match");
    else
      $display("bloom_filter_murmur3_unit: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bfm_pkg.sv
rtl/bfm_ram.sv
rtl/bfm_ctrl.sv
rtl/bfm_dpath.sv
rtl/bloom_filter_murmur3_unit.sv
rtl/bfm_checker.sv
dv/testbench.sv
